FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the barometer compensator RTL
// Each macro expects clk and rst_n to be in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsc assertion failed");

`endif

FILE: hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometer sequencer and compensator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int IN_W  = 56;   // now_ms (32) + adc_word (24)
  localparam int OUT_W = 48;   // 46 bits of fields, padded to six bytes

  localparam logic [31:0] CONV_WAIT_MS = 32'd9;
  localparam logic [18:0] TEMP_BASE    = 19'sd2000;

  localparam logic [15:0] TEMP_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] PRESS_PERIOD_RST = 16'd20;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_TEMP  = 2'd1,
    CMD_PRESS = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SENS      = 3'd0,
    REG_OFF       = 3'd1,
    REG_TCS       = 3'd2,
    REG_TCO       = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMPSENS  = 3'd5,
    REG_TEMP_PER  = 3'd6,
    REG_PRESS_PER = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] tcs;
    logic [15:0] tco;
    logic [15:0] tref;
    logic [15:0] tempsens;
  } coef_t;

  // Handshake between the sequencer and the compensation unit.
  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/bsc_mul.sv
// ----------------------------------------------------------------------------
// bsc_mul
// Shared signed 25 x 18 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_mul (
  input  wire logic               clk,
  input  wire logic signed [24:0] a,
  input  wire logic signed [17:0] b,
  output logic signed [42:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 43'(a) * 43'(b);
  end

endmodule

`default_nettype wire

FILE: hdl/bsc_comp.sv
// ----------------------------------------------------------------------------
// bsc_comp
// First-order compensation, one product per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsc_comp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire bsc_pkg::coef_t       coef,
  input  wire logic [23:0]          raw_temp,
  input  wire logic [23:0]          raw_press,
  output bsc_pkg::comp_stat_t       stat,
  output logic signed [18:0]        temp_r,
  output logic signed [22:0]        press_r
);

  typedef enum logic [3:0] {
    S_IDLE, S_DT, S_MT, S_MO, S_MS, S_SENS, S_MH, S_ML, S_ACC, S_Q, S_P
  } state_t;

  localparam logic [18:0] TEMP_BASE_S = bsc_pkg::TEMP_BASE;

  state_t             state_r, state_nxt;
  logic               done_r, done_nxt;
  logic signed [18:0] temp_nxt;
  logic signed [22:0] press_nxt;

  logic signed [24:0] dt_r, dt_nxt;
  logic signed [34:0] off_r, off_nxt;
  logic signed [33:0] sens_r, sens_nxt;
  logic signed [57:0] acc_r, acc_nxt;
  logic signed [37:0] q_r, q_nxt;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod_r;

  logic signed [42:0] prod_div;
  logic signed [57:0] prod_ext;
  logic signed [57:0] acc_div;
  logic signed [37:0] q_div;
  logic signed [24:0] press_ext;

  bsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign press_ext = $signed({1'b0, raw_press});
  assign prod_ext  = {{15{prod_r[42]}}, prod_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = dt_r;
    mul_b = $signed({2'b00, coef.tempsens});
    case (state_r)
      S_MT:    mul_b = $signed({2'b00, coef.tempsens});
      S_MO:    mul_b = $signed({2'b00, coef.tco});
      S_MS:    mul_b = $signed({2'b00, coef.tcs});
      S_MH: begin
        // Upper SENS bits, sign-extended: SENS may be negative.
        mul_a = press_ext;
        mul_b = $signed({sens_r[33], sens_r[33:17]});
      end
      S_ML: begin
        mul_a = press_ext;
        mul_b = $signed({1'b0, sens_r[16:0]});
      end
      default: mul_b = $signed({2'b00, coef.tempsens});
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    temp_nxt  = temp_r;
    press_nxt = press_r;
    dt_nxt    = dt_r;
    off_nxt   = off_r;
    sens_nxt  = sens_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    prod_div  = '0;
    acc_div   = '0;
    q_div     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DT;
        end
      end
      S_DT: begin
        dt_nxt    = $signed({1'b0, raw_temp}) - $signed({1'b0, coef.tref, 8'h00});
        state_nxt = S_MT;
      end
      S_MT: begin
        state_nxt = S_MO;
      end
      S_MO: begin
        // dT * C6 / 2^23, rounded toward zero.
        prod_div  = (prod_r + (prod_r[42] ? 43'sd8388607 : 43'sd0)) >>> 23;
        temp_nxt  = $signed(TEMP_BASE_S) + prod_div[18:0];
        state_nxt = S_MS;
      end
      S_MS: begin
        prod_div  = (prod_r + (prod_r[42] ? 43'sd127 : 43'sd0)) >>> 7;
        off_nxt   = $signed({3'b000, coef.off, 16'h0000}) + prod_div[34:0];
        state_nxt = S_SENS;
      end
      S_SENS: begin
        prod_div  = (prod_r + (prod_r[42] ? 43'sd255 : 43'sd0)) >>> 8;
        sens_nxt  = $signed({3'b000, coef.sens, 15'h0000}) + prod_div[33:0];
        state_nxt = S_MH;
      end
      S_MH: begin
        state_nxt = S_ML;
      end
      S_ML: begin
        // Upper partial product carries the weight of the low 17 SENS bits.
        acc_nxt   = prod_ext <<< 17;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = S_Q;
      end
      S_Q: begin
        acc_div   = (acc_r + (acc_r[57] ? 58'sd2097151 : 58'sd0)) >>> 21;
        q_nxt     = acc_div[37:0] - {{3{off_r[34]}}, off_r};
        state_nxt = S_P;
      end
      S_P: begin
        q_div     = (q_r + (q_r[37] ? 38'sd32767 : 38'sd0)) >>> 15;
        press_nxt = q_div[22:0];
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      temp_r  <= '0;
      press_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      temp_r  <= temp_nxt;
      press_r <= press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    off_r  <= off_nxt;
    sens_r <= sens_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;

  `BSC_ASSERT_IMP(a_start_when_idle, start, state_r == S_IDLE)
  `BSC_ASSERT_NXT(a_done_returns_idle, state_r == S_P, done_r && state_r == S_IDLE)
  `BSC_ASSERT_IMP(a_done_not_busy, done_r, state_r == S_IDLE)

endmodule

`default_nettype wire

FILE: hdl/baro_sensor_sequencer_compensator.sv
// ----------------------------------------------------------------------------
// baro_sensor_sequencer_compensator
// Conversion scheduler and first-order pressure/temperature compensation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents (lowest bit first)
//  in_      slave      now_ms[31:0], adc_word[55:32]
//  out_     master     command[1:0], adc_taken[2], temperature[21:3],
//                      pressure[44:22], data_ready[45], zero pad[47:46]
//  cfg_     write      cfg_index selects one of eight 16-bit registers
//
//  A beat that does not take the ADC word produces its result in the cycle
//  after acceptance. A beat that takes the ADC word runs the compensation
//  unit through states S_DT to S_P and its shared 25 x 18 multiplier; the
//  result goes via done_r to the output register; in_tready is low till then.
//  Reset is synchronous and active low and needs no clearing pass.
//  A stalled result holds in the output register; a new beat is taken while
//  that register drains in the same cycle.
//
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module baro_sensor_sequencer_compensator (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // now_ms[31:0], adc_word[55:32]
  input  wire logic [bsc_pkg::IN_W-1:0]  in_tdata,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // command[1:0], adc_taken[2], temperature[21:3], pressure[44:22],
  // data_ready[45], zero[47:46]
  output logic [bsc_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_wr_en,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [15:0]               cfg_data
);

  // Configuration registers.
  bsc_pkg::coef_t coef_r;
  logic [15:0]    temp_per_r;
  logic [15:0]    press_per_r;

  // Sequencer state.
  logic [31:0] last_temp_r, last_temp_nxt;
  logic [31:0] last_press_r, last_press_nxt;
  logic [31:0] last_cmd_r, last_cmd_nxt;
  logic        conv_pend_r, conv_pend_nxt;
  logic        press_pend_r, press_pend_nxt;
  logic [23:0] raw_temp_r, raw_temp_nxt;
  logic [23:0] raw_press_r, raw_press_nxt;
  logic        ready_r, ready_nxt;
  logic        wait_r, wait_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [bsc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic [31:0]          now_ms;
  logic [23:0]          adc_word;
  logic                 in_fire;
  logic                 take;
  bsc_pkg::cmd_t        cmd;
  logic [31:0]          since_temp, since_press, since_cmd;
  logic                 comp_start;
  bsc_pkg::comp_stat_t  comp_stat;
  logic signed [18:0]   temp_val;
  logic signed [22:0]   press_val;

  assign now_ms   = in_tdata[31:0];
  assign adc_word = in_tdata[55:32];

  // A new beat needs the compensation unit idle, no result pending and the output
  // register free or emptying this cycle.
  assign in_tready = !wait_r && !comp_stat.busy && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign since_temp  = now_ms - last_temp_r;
  assign since_press = now_ms - last_press_r;
  assign since_cmd   = now_ms - last_cmd_r;

  // A fresh command cannot be read in the same beat, so a read only follows
  // a conversion that was already pending.
  assign take = conv_pend_r && (since_cmd > bsc_pkg::CONV_WAIT_MS);

  always_comb begin
    cmd = bsc_pkg::CMD_NONE;
    if (!conv_pend_r) begin
      if (since_temp > {16'h0000, temp_per_r}) begin
        cmd = bsc_pkg::CMD_TEMP;
      end else if (since_press > {16'h0000, press_per_r}) begin
        cmd = bsc_pkg::CMD_PRESS;
      end
    end
  end

  always_comb begin
    last_temp_nxt  = last_temp_r;
    last_press_nxt = last_press_r;
    last_cmd_nxt   = last_cmd_r;
    conv_pend_nxt  = conv_pend_r;
    press_pend_nxt = press_pend_r;
    raw_temp_nxt   = raw_temp_r;
    raw_press_nxt  = raw_press_r;
    ready_nxt      = ready_r;
    wait_nxt       = wait_r;
    comp_start     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    if (in_fire) begin
      if (cmd != bsc_pkg::CMD_NONE) begin
        conv_pend_nxt  = 1'b1;
        press_pend_nxt = (cmd == bsc_pkg::CMD_PRESS);
        ready_nxt      = 1'b0;
        last_cmd_nxt   = now_ms;
      end
      if (take) begin
        if (press_pend_r) begin
          raw_press_nxt  = adc_word;
          last_press_nxt = now_ms;
        end else begin
          raw_temp_nxt  = adc_word;
          last_temp_nxt = now_ms;
        end
        conv_pend_nxt = 1'b0;
        comp_start    = 1'b1;
        wait_nxt      = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {2'b00, ready_nxt, press_val, temp_val, 1'b0, cmd};
      end
    end

    // The compensated result closes a beat that took the ADC word.
    if (comp_stat.done) begin
      ready_nxt     = 1'b1;
      wait_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, 1'b1, press_val, temp_val, 1'b1, bsc_pkg::CMD_NONE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r       <= '0;
      temp_per_r   <= bsc_pkg::TEMP_PERIOD_RST;
      press_per_r  <= bsc_pkg::PRESS_PERIOD_RST;
      last_temp_r  <= '0;
      last_press_r <= '0;
      last_cmd_r   <= '0;
      conv_pend_r  <= 1'b0;
      press_pend_r <= 1'b0;
      raw_temp_r   <= '0;
      raw_press_r  <= '0;
      ready_r      <= 1'b0;
      wait_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (bsc_pkg::reg_idx_t'(cfg_index))
          bsc_pkg::REG_SENS:      coef_r.sens     <= cfg_data;
          bsc_pkg::REG_OFF:       coef_r.off      <= cfg_data;
          bsc_pkg::REG_TCS:       coef_r.tcs      <= cfg_data;
          bsc_pkg::REG_TCO:       coef_r.tco      <= cfg_data;
          bsc_pkg::REG_TREF:      coef_r.tref     <= cfg_data;
          bsc_pkg::REG_TEMPSENS:  coef_r.tempsens <= cfg_data;
          bsc_pkg::REG_TEMP_PER:  temp_per_r      <= cfg_data;
          bsc_pkg::REG_PRESS_PER: press_per_r     <= cfg_data;
          default:                temp_per_r      <= temp_per_r;
        endcase
      end
      last_temp_r  <= last_temp_nxt;
      last_press_r <= last_press_nxt;
      last_cmd_r   <= last_cmd_nxt;
      conv_pend_r  <= conv_pend_nxt;
      press_pend_r <= press_pend_nxt;
      raw_temp_r   <= raw_temp_nxt;
      raw_press_r  <= raw_press_nxt;
      ready_r      <= ready_nxt;
      wait_r       <= wait_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  bsc_comp u_comp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (comp_start),
    .coef      (coef_r),
    .raw_temp  (raw_temp_nxt),
    .raw_press (raw_press_nxt),
    .stat      (comp_stat),
    .temp_r    (temp_val),
    .press_r   (press_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BSC_ASSERT_IMP(a_done_finds_output_free, comp_stat.done, !out_valid_r && wait_r)
  `BSC_ASSERT_IMP(a_no_accept_while_computing, in_fire, !comp_stat.busy && !wait_r)
  `BSC_ASSERT_IMP(a_taken_has_no_command, out_valid_r && out_data_r[2],
                  out_data_r[1:0] == bsc_pkg::CMD_NONE && out_data_r[45])

endmodule

`default_nettype wire

FILE: dv/baro_reading_pkg.sv
// ----------------------------------------------------------------------------
// baro_reading_pkg
// Reading tracker for the barometer sequencer testbench: it follows the
// conversion schedule and the compensation, and it holds the readings still
// to come out of the block.
// ----------------------------------------------------------------------------
package baro_reading_pkg;

  import bsc_pkg::*;

  typedef struct {
    cmd_t        command;
    logic        taken;
    logic [18:0] temperature;
    logic [22:0] pressure;
    logic        ready;
  } baro_reading_t;

  class reading_tracker;

    logic [15:0]   regs [8];
    logic [31:0]   last_temp_ms;
    logic [31:0]   last_press_ms;
    logic [31:0]   last_cmd_ms;
    logic          conv_busy;
    logic          press_next;
    logic [23:0]   raw_t;
    logic [23:0]   raw_p;
    logic [18:0]   temp_c;
    logic [22:0]   press_c;
    logic          ready;
    baro_reading_t pending_readings [$];
    int            fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_TEMP_PER]  = TEMP_PERIOD_RST;
      regs[REG_PRESS_PER] = PRESS_PERIOD_RST;
      last_temp_ms  = '0;
      last_press_ms = '0;
      last_cmd_ms   = '0;
      conv_busy     = 1'b0;
      press_next    = 1'b0;
      raw_t         = '0;
      raw_p         = '0;
      temp_c        = '0;
      press_c       = '0;
      ready         = 1'b0;
      fails         = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] val);
      regs[idx] = val;
    endfunction

    function int outstanding();
      return pending_readings.size();
    endfunction

    // First-order compensation in 64-bit signed arithmetic; division
    // truncates towards zero, as SystemVerilog does for signed operands.
    function void compensate();
      longint c1, c2, c3, c4, c5, c6, rt, rp, dt, off, sens, t, p;
      c1 = regs[REG_SENS];
      c2 = regs[REG_OFF];
      c3 = regs[REG_TCS];
      c4 = regs[REG_TCO];
      c5 = regs[REG_TREF];
      c6 = regs[REG_TEMPSENS];
      rt = raw_t;
      rp = raw_p;
      dt   = rt - c5 * 256;
      off  = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;
      t = 2000 + (dt * c6) / 8388608;
      p = ((rp * sens) / 2097152 - off) / 32768;
      temp_c  = t[18:0];
      press_c = p[22:0];
    endfunction

    // Called for every accepted poll beat: advances the schedule and queues
    // the reading that the block must return for it.
    function void note_poll(logic [31:0] now, logic [23:0] adc);
      baro_reading_t r;
      r.command = CMD_NONE;
      r.taken   = 1'b0;
      if (!conv_busy) begin
        if (32'(now - last_temp_ms) > {16'b0, regs[REG_TEMP_PER]}) begin
          r.command  = CMD_TEMP;
          press_next = 1'b0;
        end else if (32'(now - last_press_ms) > {16'b0, regs[REG_PRESS_PER]}) begin
          r.command  = CMD_PRESS;
          press_next = 1'b1;
        end
        if (r.command != CMD_NONE) begin
          conv_busy   = 1'b1;
          ready       = 1'b0;
          last_cmd_ms = now;
        end
      end
      if (conv_busy && 32'(now - last_cmd_ms) > CONV_WAIT_MS) begin
        if (press_next) begin
          raw_p         = adc;
          last_press_ms = now;
        end else begin
          raw_t        = adc;
          last_temp_ms = now;
        end
        conv_busy = 1'b0;
        r.taken   = 1'b1;
        compensate();
        ready = 1'b1;
      end
      r.temperature = temp_c;
      r.pressure    = press_c;
      r.ready       = ready;
      pending_readings.push_back(r);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      fails++;
    endtask

    task check_reading(logic [OUT_W-1:0] beat);
      baro_reading_t want;
      if (pending_readings.size() == 0) begin
        report($sformatf("reading beat %h with none outstanding", beat));
        return;
      end
      want = pending_readings.pop_front();
      if (beat[1:0] != want.command)
        report($sformatf("command %0d, wanted %0d", beat[1:0], want.command));
      if (beat[2] != want.taken)
        report($sformatf("adc_taken %0b, wanted %0b", beat[2], want.taken));
      if (beat[21:3] != want.temperature)
        report($sformatf("temperature %h, wanted %h", beat[21:3], want.temperature));
      if (beat[44:22] != want.pressure)
        report($sformatf("pressure %h, wanted %h", beat[44:22], want.pressure));
      if (beat[45] != want.ready)
        report($sformatf("data_ready %0b, wanted %0b", beat[45], want.ready));
    endtask

  endclass

endpackage

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the barometer conversion sequencer and compensator. Poll
// beats carrying a millisecond time and an ADC word are driven into the
// block; every reading that comes back is checked field by field against a
// tracker that follows the schedule and the compensation arithmetic.
// ----------------------------------------------------------------------------
module tb_top;

  import bsc_pkg::*;
  import baro_reading_pkg::*;

  logic                clk;
  logic                rst_n;
  // now_ms[31:0], adc_word[55:32]
  logic [IN_W-1:0]     in_tdata;
  logic                in_tvalid;
  logic                in_tready;
  // command[1:0], adc_taken[2], temperature[21:3], pressure[44:22],
  // data_ready[45], zero[47:46]
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic                cfg_wr_en;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;

  // When set, neither side inserts gaps or stalls; used for the final phase.
  logic                calm = 1'b0;
  // Running millisecond time handed to the block with each poll beat.
  logic [31:0]         clock_ms;
  reading_tracker      tracker;

  baro_sensor_sequencer_compensator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hand one poll beat to the block. The task is entered and left at a
  // falling edge, so that back-to-back beats keep in_tvalid high without
  // lowering it in between. The tracker is updated at the accepting edge.
  task automatic send_poll(logic [31:0] now, logic [23:0] adc);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {adc, now};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    tracker.note_poll(now, adc);
    @(negedge clk);
  endtask

  // Write all eight registers, one per cycle. Only called while the block
  // has nothing in flight.
  task automatic program_regs(logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      tracker.set_reg(reg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every queued reading has come back, then let the block idle
  // before the next phase.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    repeat (16) @(negedge clk);
  endtask

  // Random polling: mostly forward steps of up to step_max milliseconds so that the
  // temperature and pressure conversions cycle through, with the odd jump to
  // an arbitrary time or a short step backwards as noise.
  task automatic poll_run(int count, int step_max);
    int          pick;
    logic [23:0] adc;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        clock_ms = $urandom();
      end else if (pick < 6) begin
        clock_ms = clock_ms - $urandom_range(1, 40);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        adc = 24'h000000;
      end else if (pick == 1) begin
        adc = 24'hFFFFFF;
      end else begin
        adc = 24'($urandom());
      end
      send_poll(clock_ms, adc);
    end
  endtask

  function automatic logic [15:0] rand_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  // The receiver alternates at random between stretches of readiness and stall
  // bursts; once calm is set it simply stays ready.
  initial begin : reading_sink
    int   span;
    logic stall;
    out_tready = 1'b0;
    forever begin
      span  = $urandom_range(1, 6);
      stall = !calm && ($urandom_range(0, 2) == 0);
      repeat (span) begin
        @(negedge clk);
        out_tready <= !stall;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_reading(out_tdata);
    end
  end

  initial begin : stimulus
    logic [15:0] vals [8];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    clock_ms  = '0;
    tracker   = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polling with the reset settings: coefficients all zero, so
    // the first compensation gives the bare 20.00 degC base and zero
    // pressure.
    send_poll(32'd0, 24'h000000);       // nothing due yet
    send_poll(32'd20, 24'h123456);      // pressure period reached but not exceeded
    send_poll(32'd21, 24'h654321);      // pressure conversion starts
    send_poll(32'd30, 24'hFFFFFF);      // exactly the conversion wait: not read
    send_poll(32'd31, 24'hFFFFFF);      // raw pressure taken
    send_poll(32'd1001, 24'h000001);    // both due: temperature wins
    send_poll(32'd1011, 24'h800000);    // raw temperature taken
    send_poll(32'd1012, 24'h000000);    // pressure conversion starts
    send_poll(32'hFFFFFFFF, 24'hABCDEF); // time runs backwards: read at once
    send_poll(32'd0, 24'h000000);       // wrapped interval: temperature again
    send_poll(32'd10, 24'h7FFFFF);      // raw temperature taken
    settle();

    // Typical factory calibration, default periods.
    vals = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312,
             16'd1000, 16'd20};
    program_regs(vals);
    send_poll(32'd30, 24'h000000);      // pressure conversion starts
    send_poll(32'd40, 24'h000000);      // smallest raw pressure
    send_poll(32'd1011, 24'h000000);    // temperature conversion starts
    send_poll(32'd1021, 24'hFFFFFF);    // largest raw temperature
    send_poll(32'd1042, 24'h000000);
    send_poll(32'd1052, 24'hFFFFFF);    // largest raw pressure
    send_poll(32'd2022, 24'h000000);
    send_poll(32'd2032, 24'h000000);    // smallest raw temperature
    send_poll(32'd2053, 24'h000000);
    send_poll(32'd2063, 24'd9085466);   // a typical raw pressure
    clock_ms = 32'd2063;
    settle();

    // Short periods so that conversions follow each other closely.
    vals[REG_TEMP_PER]  = 16'd30;
    vals[REG_PRESS_PER] = 16'd4;
    program_regs(vals);
    poll_run(350, 6);
    settle();

    // Every coefficient at its maximum; zero periods, so a conversion is
    // due as soon as any time has passed.
    vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'd0, 16'd0};
    program_regs(vals);
    poll_run(300, 4);
    settle();

    // Zero coefficients and the longest periods; large time steps so that
    // the periods are still exceeded now and then.
    vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
    program_regs(vals);
    poll_run(250, 20000);
    settle();

    // Random calibration and moderate periods.
    foreach (vals[i]) vals[i] = rand_word();
    vals[REG_TEMP_PER]  = 16'($urandom_range(0, 100));
    vals[REG_PRESS_PER] = 16'($urandom_range(0, 100));
    program_regs(vals);
    poll_run(400, 12);
    settle();

    // Final phase with both sides running flat out.
    foreach (vals[i]) vals[i] = rand_word();
    vals[REG_TEMP_PER]  = 16'($urandom_range(10, 60));
    vals[REG_PRESS_PER] = 16'($urandom_range(0, 10));
    program_regs(vals);
    calm = 1'b1;
    poll_run(450, 8);
    settle();

    if (tracker.fails == 0) begin
      $display("PASS baro_sensor_sequencer_compensator");
    end else begin
      $display("FAIL baro_sensor_sequencer_compensator");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #3000000;
    $display("FAIL baro_sensor_sequencer_compensator");
    $finish;
  end

endmodule
